/* src/bdlp_pkg.sv */
`timescale 1ns / 1ps

package bdlp_pkg;

  // Fixed field widths.
  localparam int RAW_BITS   = 14;
  localparam int TIME_W     = 32;
  localparam int BUTTON_W   = 4;
  localparam int KIND_W     = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Event kinds as they appear in edge_kind.
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LONG    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET = 16'd800;

  typedef struct packed {
    logic                func;
    logic [TIME_W-1:0]   now_ms;
    logic [RAW_BITS-1:0] raw_levels;
  } item_t;

  typedef struct packed {
    logic [BUTTON_W-1:0] button;
    logic [KIND_W-1:0]   edge_kind;
    logic [TIME_W-1:0]   event_time;
    logic                last;
  } evt_t;

  typedef enum logic {
    CMD_UPDATE,
    CMD_SEED
  } cmd_kind_t;

  // A classified item as it sits in the queue.
  typedef struct packed {
    cmd_kind_t           kind;
    logic [TIME_W-1:0]   now_ms;
    logic [RAW_BITS-1:0] raw_levels;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEB,
    ST_LONG,
    ST_FLUSH
  } state_t;

endpackage

/* src/bdlp_front.sv */
`timescale 1ns / 1ps

module bdlp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bdlp_pkg::item_t   item,
  output logic              head_valid,
  output bdlp_pkg::cmd_t    head,
  input  logic              pop
);

  bdlp_pkg::cmd_t                         queue [bdlp_pkg::QUEUE_DEPTH];
  logic [bdlp_pkg::QUEUE_PTR_W-1:0]       wr_ptr;
  logic [bdlp_pkg::QUEUE_PTR_W-1:0]       rd_ptr;
  logic [bdlp_pkg::QUEUE_CNT_W-1:0]       count;
  logic                                   push;
  bdlp_pkg::cmd_t                         cmd;

  assign item_stall = (count == bdlp_pkg::QUEUE_CNT_W'(bdlp_pkg::QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];

  // Classify the word as a seed or an update command.
  always_comb begin
    cmd.kind       = item.func ? bdlp_pkg::CMD_SEED : bdlp_pkg::CMD_UPDATE;
    cmd.now_ms     = item.now_ms;
    cmd.raw_levels = item.raw_levels;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bdlp_pkg::QUEUE_CNT_W'(bdlp_pkg::QUEUE_DEPTH))
    else $error("command queue count exceeds its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("command popped from an empty queue");

  a_push_pop_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with mismatched pointers");

endmodule

/* src/bdlp_back.sv */
`timescale 1ns / 1ps

module bdlp_back #(
  parameter int NUM_BUTTONS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  input  bdlp_pkg::cmd_t                     head,
  output logic                               pop,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]    settle_ms,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]    long_press_ms,
  output logic                               evt_valid,
  input  logic                               evt_stall,
  output bdlp_pkg::evt_t                     evt
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  bdlp_pkg::state_t                  state;
  bdlp_pkg::state_t                  state_next;
  logic [IDX_W-1:0]                  idx;
  logic [IDX_W-1:0]                  idx_next;

  logic [NUM_BUTTONS-1:0]            previous_raw;
  logic [NUM_BUTTONS-1:0]            stable_level;
  logic [NUM_BUTTONS-1:0]            long_sent;
  logic [bdlp_pkg::TIME_W-1:0]       change_time [NUM_BUTTONS];
  logic [bdlp_pkg::TIME_W-1:0]       press_time  [NUM_BUTTONS];

  logic [NUM_BUTTONS-1:0]            raw_ext;
  logic                              r;
  logic                              changed;
  logic [bdlp_pkg::TIME_W-1:0]       age;
  logic [bdlp_pkg::TIME_W-1:0]       press_age;
  logic                              flip;
  logic                              long_hit;

  logic                              out_free;
  logic                              can_take;
  logic                              ev_valid;
  logic [bdlp_pkg::KIND_W-1:0]       ev_kind;
  logic                              commit_seed;
  logic                              commit_deb;
  logic                              commit_long;
  logic                              flush;
  logic                              take;
  logic                              load;

  logic                              pend_valid;
  logic [bdlp_pkg::BUTTON_W-1:0]     pend_button;
  logic [bdlp_pkg::KIND_W-1:0]       pend_kind;
  logic [bdlp_pkg::TIME_W-1:0]       pend_time;

  // Buttons past the raw input width always read released.
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_raw
    if (g < bdlp_pkg::RAW_BITS) begin : g_in
      assign raw_ext[g] = head.raw_levels[g];
    end else begin : g_off
      assign raw_ext[g] = 1'b0;
    end
  end

  assign r         = raw_ext[idx];
  assign changed   = (r != previous_raw[idx]);
  assign age       = changed ? '0 : (head.now_ms - change_time[idx]);
  assign flip      = (age >= {16'b0, settle_ms}) && (r != stable_level[idx]);
  assign press_age = head.now_ms - press_time[idx];
  assign long_hit  = stable_level[idx] && !long_sent[idx] &&
                     (press_age >= {16'b0, long_press_ms});

  assign out_free  = !evt_valid || !evt_stall;
  assign can_take  = !pend_valid || out_free;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pop         = 1'b0;
    ev_valid    = 1'b0;
    ev_kind     = bdlp_pkg::KIND_PRESS;
    commit_seed = 1'b0;
    commit_deb  = 1'b0;
    commit_long = 1'b0;
    flush       = 1'b0;
    case (state)
      bdlp_pkg::ST_IDLE: begin
        if (head_valid) begin
          if (head.kind == bdlp_pkg::CMD_SEED) begin
            commit_seed = 1'b1;
            pop         = 1'b1;
          end else begin
            idx_next   = '0;
            state_next = bdlp_pkg::ST_DEB;
          end
        end
      end
      bdlp_pkg::ST_DEB: begin
        ev_valid = flip;
        ev_kind  = r ? bdlp_pkg::KIND_PRESS : bdlp_pkg::KIND_RELEASE;
        if (!flip || can_take) begin
          commit_deb = 1'b1;
          state_next = bdlp_pkg::ST_LONG;
        end
      end
      bdlp_pkg::ST_LONG: begin
        ev_valid = long_hit;
        ev_kind  = bdlp_pkg::KIND_LONG;
        if (!long_hit || can_take) begin
          commit_long = 1'b1;
          if (idx == IDX_W'(NUM_BUTTONS - 1)) begin
            state_next = bdlp_pkg::ST_FLUSH;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = bdlp_pkg::ST_DEB;
          end
        end
      end
      bdlp_pkg::ST_FLUSH: begin
        if (!pend_valid) begin
          pop        = 1'b1;
          state_next = bdlp_pkg::ST_IDLE;
        end else if (out_free) begin
          flush      = 1'b1;
          pop        = 1'b1;
          state_next = bdlp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bdlp_pkg::ST_IDLE;
      end
    endcase
  end

  // A new event pushes the held one out with last clear; the final held
  // event leaves on flush with last set.
  assign take = ev_valid && (commit_deb || commit_long);
  assign load = (take && pend_valid) || flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdlp_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      evt_valid  <= 1'b0;
    end else begin
      if (take) begin
        pend_valid <= 1'b1;
      end else if (flush) begin
        pend_valid <= 1'b0;
      end
      evt_valid <= load || (evt_valid && evt_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_button <= bdlp_pkg::BUTTON_W'(idx);
      pend_kind   <= ev_kind;
      pend_time   <= head.now_ms;
    end
    if (load) begin
      evt.button     <= pend_button;
      evt.edge_kind  <= pend_kind;
      evt.event_time <= pend_time;
      evt.last       <= flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw <= '0;
      stable_level <= '0;
      long_sent    <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        change_time[i] <= '0;
        press_time[i]  <= '0;
      end
    end else begin
      if (commit_seed) begin
        previous_raw <= raw_ext;
        stable_level <= raw_ext;
      end
      if (commit_deb) begin
        previous_raw[idx] <= r;
        if (changed) begin
          change_time[idx] <= head.now_ms;
        end
        if (flip) begin
          stable_level[idx] <= r;
          if (r) begin
            press_time[idx] <= head.now_ms;
            long_sent[idx]  <= 1'b0;
          end
        end
      end
      if (commit_long && long_hit) begin
        long_sent[idx] <= 1'b1;
      end
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == bdlp_pkg::ST_IDLE) |-> !pend_valid)
    else $error("held event left over between commands");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == bdlp_pkg::ST_IDLE))
    else $error("walk did not return to idle after a pop");

  a_long_pressed: assert property (@(posedge clk) disable iff (rst)
    (state == bdlp_pkg::ST_LONG && long_hit) |-> stable_level[idx])
    else $error("long press flagged on a released button");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("output register loaded while its word is stalled");

endmodule

/* src/button_debounce_long_press.sv */
`timescale 1ns / 1ps

// Channel   Handshake                 Payload                Meaning
// item      item_valid / item_stall   item (item_t)          timestamped raw levels
// evt       evt_valid / evt_stall     evt (evt_t)            press, release, long press
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data    debounce and long-press times
//
// An update word walks the buttons one at a time, a debounce step then a
// long-press step per button, after a start step and before a flush step that
// hands over the final held event, if any; evt_stall holding the output register
// can stall the walk. A seed word is taken straight from the idle state.
// Reset is synchronous on rst and clears all per-button state and the queue.
// A two-word command queue decouples the input from the button walk, and the
// output register with one held event lets the walk run on while a word waits.

module button_debounce_long_press #(
  parameter int NUM_BUTTONS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  bdlp_pkg::item_t                       item,
  output logic                                  evt_valid,
  input  logic                                  evt_stall,
  output bdlp_pkg::evt_t                        evt,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [bdlp_pkg::CFG_DATA_W-1:0] settle_ms;
  logic [bdlp_pkg::CFG_DATA_W-1:0] long_press_ms;
  logic                            head_valid;
  bdlp_pkg::cmd_t                  head;
  logic                            pop;

  // Configuration writes are always taken; the user must send them only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms     <= bdlp_pkg::DEBOUNCE_RESET;
      long_press_ms <= bdlp_pkg::LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bdlp_pkg::CFG_DEBOUNCE:   settle_ms     <= cfg_data;
        bdlp_pkg::CFG_LONG_PRESS: long_press_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front classifies each word and queues it as a command.
  bdlp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // The back walks the buttons and produces the event words.
  bdlp_back #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .settle_ms     (settle_ms),
    .long_press_ms (long_press_ms),
    .evt_valid     (evt_valid),
    .evt_stall     (evt_stall),
    .evt           (evt)
  );

endmodule

/* bench/tb_button_debounce_long_press.sv */
`timescale 1ns / 1ps

// Self-checking bench for the debounced button bank. Words of timestamped raw
// levels go in, press, release and long-press events come out. A behavioral
// model of the bank runs beside the block: every accepted input word updates
// that model, and the events it predicts are queued in order. Every event the
// block hands over is compared field by field with the oldest prediction.

module tb_button_debounce_long_press;

  localparam int NUM_BUTTONS = 14;

  // The bench runs at a 12 ns clock period.
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 5;

  // Each side leaves a gap in about this many cycles out of a hundred.
  localparam int IDLE_PCT = 22;

  // An update word walks all buttons while it sits at the head of the command
  // queue, and one more word can wait behind it. After the last event has arrived we
  // give the block this many quiet cycles before touching its registers.
  localparam int IDLE_GUARD = 128;

  // The run fails if nothing is accepted on any channel for this long. The
  // longest legal silence is the output hold-off below plus the guard above.
  localparam int WATCHDOG_LIMIT = 2000;

  // Once this many words have gone in, the event side holds off for a long
  // stretch. The sender keeps going, so the queue fills and the input stalls.
  localparam int HOLDOFF_AT = 40;
  localparam int HOLDOFF_CYCLES = 300;

  // Between these word counts neither side leaves any gap.
  localparam int GAPLESS_FROM = 100;
  localparam int GAPLESS_TO = 160;

  typedef enum logic [1:0] {
    STEP_WORD,
    STEP_CONFIG,
    STEP_SETTLE
  } step_kind_t;

  // One entry of the stimulus plan: an input word, a register write, or a
  // pause until every predicted event has been seen.
  typedef struct packed {
    step_kind_t                           kind;
    bdlp_pkg::item_t                      word;
    logic [bdlp_pkg::CFG_IDX_W-1:0]       reg_index;
    logic [bdlp_pkg::CFG_DATA_W-1:0]      reg_value;
  } stim_step_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            item_valid = 1'b0;
  logic                            item_stall;
  bdlp_pkg::item_t                 item = '0;
  logic                            evt_valid;
  logic                            evt_stall = 1'b0;
  bdlp_pkg::evt_t                  evt;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index = bdlp_pkg::CFG_DEBOUNCE;
  logic [bdlp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stim_step_t     pending_steps[$];
  bdlp_pkg::evt_t predicted_events[$];

  // Model of the button bank: raw level last seen, accepted level, when the
  // raw level last changed, when the current press was accepted, and whether
  // that press has already reported its long press.
  logic [NUM_BUTTONS-1:0]          raw_seen;
  logic [NUM_BUTTONS-1:0]          settled;
  logic [NUM_BUTTONS-1:0]          long_reported;
  logic [bdlp_pkg::TIME_W-1:0]     level_changed_at [NUM_BUTTONS];
  logic [bdlp_pkg::TIME_W-1:0]     press_started_at [NUM_BUTTONS];
  logic [bdlp_pkg::CFG_DATA_W-1:0] debounce_window;
  logic [bdlp_pkg::CFG_DATA_W-1:0] long_hold;

  // Handshake results from the last rising edge, used by the falling-edge
  // drivers to decide whether a word has left.
  logic word_taken = 1'b0;
  logic cfg_taken = 1'b0;

  int  words_taken = 0;
  int  seeds_taken = 0;
  int  events_checked = 0;
  int  cfg_writes = 0;
  int  failures = 0;
  int  idle_cycles = 0;
  int  quiet_cycles = 0;
  int  holdoff_left = 0;
  bit  holdoff_done = 1'b0;
  bit  stimulus_sent = 1'b0;

  wire no_gaps = (words_taken >= GAPLESS_FROM) && (words_taken < GAPLESS_TO);

  button_debounce_long_press #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Runs one accepted word through the model and queues the events it causes.
  // Buttons are visited in index order; a button can produce a press and a
  // long press in the same word when the long-press time is already met.
  function automatic void predict_button_events(input bdlp_pkg::item_t w);
    bdlp_pkg::evt_t              batch[$];
    bdlp_pkg::evt_t              ev;
    logic                        lvl;
    logic [bdlp_pkg::TIME_W-1:0] held_ms;
    if (w.func == bdlp_pkg::CMD_SEED) begin
      settled = w.raw_levels;
      raw_seen = w.raw_levels;
      return;
    end
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      lvl = w.raw_levels[b];
      if (lvl != raw_seen[b]) begin
        raw_seen[b] = lvl;
        level_changed_at[b] = w.now_ms;
      end
      ev.button = b[bdlp_pkg::BUTTON_W-1:0];
      ev.event_time = w.now_ms;
      ev.last = 1'b0;
      held_ms = w.now_ms - level_changed_at[b];
      if (held_ms >= debounce_window && lvl != settled[b]) begin
        settled[b] = lvl;
        if (lvl) begin
          press_started_at[b] = w.now_ms;
          long_reported[b] = 1'b0;
          ev.edge_kind = bdlp_pkg::KIND_PRESS;
        end else begin
          ev.edge_kind = bdlp_pkg::KIND_RELEASE;
        end
        batch.push_back(ev);
      end
      held_ms = w.now_ms - press_started_at[b];
      if (settled[b] && !long_reported[b] && held_ms >= long_hold) begin
        long_reported[b] = 1'b1;
        ev.edge_kind = bdlp_pkg::KIND_LONG;
        batch.push_back(ev);
      end
    end
    if (batch.size() > 0) begin
      ev = batch.pop_back();
      ev.last = 1'b1;
      batch.push_back(ev);
    end
    foreach (batch[k]) predicted_events.push_back(batch[k]);
  endfunction

  task automatic add_word(input logic func, input logic [bdlp_pkg::TIME_W-1:0] now_ms,
                          input logic [bdlp_pkg::RAW_BITS-1:0] levels);
    stim_step_t s;
    s = '0;
    s.kind = STEP_WORD;
    s.word.func = func;
    s.word.now_ms = now_ms;
    s.word.raw_levels = levels;
    pending_steps.push_back(s);
  endtask

  // A register write always follows a pause, so the block is idle when it lands.
  task automatic add_config(input logic [bdlp_pkg::CFG_IDX_W-1:0] index,
                            input logic [bdlp_pkg::CFG_DATA_W-1:0] value);
    stim_step_t s;
    s = '0;
    s.kind = STEP_CONFIG;
    s.reg_index = index;
    s.reg_value = value;
    pending_steps.push_back(s);
  endtask

  task automatic add_settle();
    stim_step_t s;
    s = '0;
    s.kind = STEP_SETTLE;
    pending_steps.push_back(s);
  endtask

  // Mostly a clock that moves forward in small steps with buttons that bounce
  // now and then, so debounce windows both expire and get restarted. A few
  // words reseed the bank and a few jump to arbitrary times and levels.
  task automatic add_random_phase(input int words, input int max_step, input int flip_pct,
                                  input logic [bdlp_pkg::TIME_W-1:0] start_ms);
    logic [bdlp_pkg::TIME_W-1:0]   clock_ms;
    logic [bdlp_pkg::RAW_BITS-1:0] levels;
    logic                          func;
    int                            roll;
    clock_ms = start_ms;
    levels = bdlp_pkg::RAW_BITS'($urandom());
    for (int n = 0; n < words; n++) begin
      func = bdlp_pkg::CMD_UPDATE;
      roll = $urandom_range(99);
      if (roll < 4) begin
        func = bdlp_pkg::CMD_SEED;
        levels = bdlp_pkg::RAW_BITS'($urandom());
      end else if (roll < 8) begin
        clock_ms = $urandom();
        levels = bdlp_pkg::RAW_BITS'($urandom());
      end else begin
        clock_ms = clock_ms + $urandom_range(max_step);
        for (int b = 0; b < bdlp_pkg::RAW_BITS; b++)
          if ($urandom_range(99) < flip_pct) levels[b] = ~levels[b];
      end
      add_word(func, clock_ms, levels);
    end
  endtask

  // Sender. A word stays on the bus until it is taken. A register write or a
  // pause waits at the head of the plan until no events are outstanding.
  always @(negedge clk) begin
    logic       word_hold;
    logic       cfg_hold;
    stim_step_t step;
    if (!rst) begin
      word_hold = item_valid && !word_taken;
      cfg_hold = cfg_valid && !cfg_taken;
      if (!word_hold && !cfg_hold) begin
        if (pending_steps.size() == 0) begin
          stimulus_sent = 1'b1;
        end else begin
          step = pending_steps[0];
          if (step.kind == STEP_WORD) begin
            if (no_gaps || $urandom_range(99) >= IDLE_PCT) begin
              item <= step.word;
              word_hold = 1'b1;
              pending_steps.delete(0);
            end
          end else begin
            quiet_cycles = (predicted_events.size() == 0) ? quiet_cycles + 1 : 0;
            if (quiet_cycles >= ((step.kind == STEP_CONFIG) ? IDLE_GUARD : 1)) begin
              if (step.kind == STEP_CONFIG) begin
                cfg_index <= step.reg_index;
                cfg_data <= step.reg_value;
                cfg_hold = 1'b1;
              end
              quiet_cycles = 0;
              pending_steps.delete(0);
            end
          end
        end
      end
      item_valid <= word_hold;
      cfg_valid <= cfg_hold;
    end
  end

  // Event receiver. Random stalls, one long hold-off, and a gapless stretch.
  always @(negedge clk) begin
    if (!rst) begin
      if (holdoff_left > 0) begin
        holdoff_left = holdoff_left - 1;
        evt_stall <= 1'b1;
      end else if (!holdoff_done && words_taken >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES - 1;
        evt_stall <= 1'b1;
      end else if (no_gaps) begin
        evt_stall <= 1'b0;
      end else begin
        evt_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Everything that crosses a handshake is seen here, at the rising edge.
  always @(posedge clk) begin
    bdlp_pkg::evt_t want;
    logic           any_taken;
    if (rst) begin
      word_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      word_taken <= item_valid && !item_stall;
      cfg_taken <= cfg_valid && cfg_ready;
      any_taken = 1'b0;

      if (item_valid && !item_stall) begin
        predict_button_events(item);
        words_taken = words_taken + 1;
        if (item.func == bdlp_pkg::CMD_SEED) seeds_taken = seeds_taken + 1;
        any_taken = 1'b1;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bdlp_pkg::CFG_DEBOUNCE: debounce_window = cfg_data;
          bdlp_pkg::CFG_LONG_PRESS: long_hold = cfg_data;
          default: ;
        endcase
        cfg_writes = cfg_writes + 1;
        any_taken = 1'b1;
      end

      if (evt_valid && !evt_stall) begin
        any_taken = 1'b1;
        if (predicted_events.size() == 0) begin
          $error("event with nothing predicted: button %0d kind %0d time %0h",
                 evt.button, evt.edge_kind, evt.event_time);
          failures = failures + 1;
        end else begin
          want = predicted_events.pop_front();
          events_checked = events_checked + 1;
          if (evt.button !== want.button) begin
            $error("button: expected %0d, got %0d", want.button, evt.button);
            failures = failures + 1;
          end
          if (evt.edge_kind !== want.edge_kind) begin
            $error("edge_kind: expected %0d, got %0d", want.edge_kind, evt.edge_kind);
            failures = failures + 1;
          end
          if (evt.event_time !== want.event_time) begin
            $error("event_time: expected %0h, got %0h", want.event_time, evt.event_time);
            failures = failures + 1;
          end
          if (evt.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, evt.last);
            failures = failures + 1;
          end
        end
      end

      idle_cycles = any_taken ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d events outstanding",
                 idle_cycles, predicted_events.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    // The model starts from the reset state of the block.
    raw_seen = '0;
    settled = '0;
    long_reported = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      level_changed_at[b] = '0;
      press_started_at[b] = '0;
    end
    debounce_window = bdlp_pkg::DEBOUNCE_RESET;
    long_hold = bdlp_pkg::LONG_PRESS_RESET;

    // Directed part at the reset settings. Updates arrive before any seed, so
    // the bank works from its cleared state. All buttons go down, settle,
    // reach their long press, then come up again.
    add_word(bdlp_pkg::CMD_UPDATE, 32'd0, '0);
    add_word(bdlp_pkg::CMD_UPDATE, 32'd5, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'd30, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'd900, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'd901, '0);
    add_word(bdlp_pkg::CMD_UPDATE, 32'd921, '0);
    // A seed takes the raw levels as settled without any event.
    add_word(bdlp_pkg::CMD_SEED, 32'd1000, 14'h2AAA);
    add_word(bdlp_pkg::CMD_UPDATE, 32'd1001, 14'h1555);
    add_settle();

    // Zero debounce and zero long-press time: every settled press also fires
    // its long press in the same word, up to two events per button.
    add_config(bdlp_pkg::CFG_DEBOUNCE, '0);
    add_config(bdlp_pkg::CFG_LONG_PRESS, '0);
    add_word(bdlp_pkg::CMD_UPDATE, 32'd2000, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'd2001, '0);
    add_word(bdlp_pkg::CMD_UPDATE, 32'd2002, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'hFFFF_FFF0, '0);

    // Largest windows, with the debounce measured across the wrap of the
    // millisecond counter.
    add_config(bdlp_pkg::CFG_DEBOUNCE, '1);
    add_config(bdlp_pkg::CFG_LONG_PRESS, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'hFFFF_FFF8, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'h0000_FFF0, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'h0000_FFF7, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'h0001_FFF6, '1);
    add_word(bdlp_pkg::CMD_UPDATE, 32'h0001_FFF7, 14'h0F0F);

    // Random part. Short windows first, where events are dense; the output
    // hold-off falls in this phase.
    add_config(bdlp_pkg::CFG_DEBOUNCE, 16'd3);
    add_config(bdlp_pkg::CFG_LONG_PRESS, 16'd12);
    add_random_phase(60, 3, 12, $urandom());

    // Back to the reset values, starting just short of the counter wrap.
    add_config(bdlp_pkg::CFG_DEBOUNCE, bdlp_pkg::DEBOUNCE_RESET);
    add_config(bdlp_pkg::CFG_LONG_PRESS, bdlp_pkg::LONG_PRESS_RESET);
    add_random_phase(55, 60, 10, 32'hFFFF_F000);

    // No debounce at all and a long press that never comes in practice.
    add_config(bdlp_pkg::CFG_DEBOUNCE, '0);
    add_config(bdlp_pkg::CFG_LONG_PRESS, '1);
    add_random_phase(50, 5, 20, $urandom());

    // Random small settings to finish.
    add_config(bdlp_pkg::CFG_DEBOUNCE, 16'($urandom_range(10)));
    add_config(bdlp_pkg::CFG_LONG_PRESS, 16'($urandom_range(40)));
    add_random_phase(55, 8, 15, $urandom());
    add_settle();

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    wait (stimulus_sent && predicted_events.size() == 0);
    repeat (IDLE_GUARD) @(posedge clk);

    $display("Sent %0d words (%0d seeds) and %0d register writes; checked %0d events,",
             words_taken, seeds_taken, cfg_writes, events_checked);
    $display("with a %0d-cycle output hold-off and a gapless stretch on both sides.",
             HOLDOFF_CYCLES);
    if (failures == 0 && predicted_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d events never seen", failures, predicted_events.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/bdlp_pkg.sv
src/bdlp_front.sv
src/bdlp_back.sv
src/button_debounce_long_press.sv
bench/tb_button_debounce_long_press.sv
